// ===== src/ldlb_pkg.sv =====
package ldlb_pkg;

   // Field widths
   localparam int TIME_W   = 20;
   localparam int REPS_W   = 4;
   localparam int MAX_REPS = 8;
   localparam int BOUND_W  = 32;

   // Internal widths: products of a period and a count, signed working values,
   // and the remainder unit.
   localparam int PROD_W = 24;
   localparam int CALC_W = 28;
   localparam int MAG_W  = 27;
   localparam int REM_W  = 25;
   localparam int CNT_W  = 5;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD_T,
      ST_WAIT_T,
      ST_GCD_K,
      ST_WAIT_K,
      ST_MOD_M,
      ST_WAIT_M,
      ST_PREP,
      ST_MOD_A,
      ST_WAIT_A,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic gcd_start;
      logic gcd_sel;
      logic gt_save;
      logic gk_save;
      logic mod_start;
      logic mod_sel;
      logic m_save;
      logic diff_save;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic mod_done;
      logic last_pair;
      logic out_free;
   } status_type;

endpackage

// ===== src/ldlb_ctrl.sv =====
module ldlb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ldlb_pkg::status_type status,
   output ldlb_pkg::cmd_type  cmd
);

   ldlb_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldlb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ldlb_pkg::ST_IDLE:   if (req_tvalid) state_in = ldlb_pkg::ST_GCD_T;
         ldlb_pkg::ST_GCD_T:  state_in = ldlb_pkg::ST_WAIT_T;
         ldlb_pkg::ST_WAIT_T: if (status.gcd_done) state_in = ldlb_pkg::ST_GCD_K;
         ldlb_pkg::ST_GCD_K:  state_in = ldlb_pkg::ST_WAIT_K;
         ldlb_pkg::ST_WAIT_K: if (status.gcd_done) state_in = ldlb_pkg::ST_MOD_M;
         ldlb_pkg::ST_MOD_M:  state_in = ldlb_pkg::ST_WAIT_M;
         ldlb_pkg::ST_WAIT_M: if (status.mod_done) state_in = ldlb_pkg::ST_PREP;
         ldlb_pkg::ST_PREP:   state_in = ldlb_pkg::ST_MOD_A;
         ldlb_pkg::ST_MOD_A:  state_in = ldlb_pkg::ST_WAIT_A;
         ldlb_pkg::ST_WAIT_A: if (status.mod_done) state_in = ldlb_pkg::ST_EMIT;
         ldlb_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.last_pair ? ldlb_pkg::ST_IDLE : ldlb_pkg::ST_PREP;
            end
         end
         default: state_in = ldlb_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ldlb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ldlb_pkg::ST_GCD_T:  cmd.gcd_start = 1'b1;
         ldlb_pkg::ST_WAIT_T: cmd.gt_save = status.gcd_done;
         ldlb_pkg::ST_GCD_K: begin
            cmd.gcd_start = 1'b1;
            cmd.gcd_sel   = 1'b1;
         end
         ldlb_pkg::ST_WAIT_K: cmd.gk_save = status.gcd_done;
         ldlb_pkg::ST_MOD_M:  cmd.mod_start = 1'b1;
         ldlb_pkg::ST_WAIT_M: cmd.m_save = status.mod_done;
         ldlb_pkg::ST_PREP:   cmd.diff_save = 1'b1;
         ldlb_pkg::ST_MOD_A: begin
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = 1'b1;
         end
         ldlb_pkg::ST_WAIT_A: cmd.mod_sel = 1'b1;
         ldlb_pkg::ST_EMIT: begin
            cmd.mod_sel = 1'b1;
            cmd.emit    = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== src/ldlb_datapath.sv =====
module ldlb_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ldlb_pkg::cmd_type                  cmd,
   output ldlb_pkg::status_type               status,
   input  logic [ldlb_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ldlb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int TW = ldlb_pkg::TIME_W;
   localparam int RW = ldlb_pkg::REPS_W;
   localparam int PW = ldlb_pkg::PROD_W;
   localparam int CW = ldlb_pkg::CALC_W;
   localparam int MW = ldlb_pkg::MAG_W;
   localparam int EW = ldlb_pkg::REM_W;
   localparam int NW = ldlb_pkg::CNT_W;
   localparam int BW = ldlb_pkg::BOUND_W;

   // Request fields
   logic [TW-1:0] f_ti, f_tj, f_di, f_ri, f_rj;
   logic [RW-1:0] f_ki, f_kj;
   assign f_ti = req_tdata[TW-1:0];
   assign f_tj = req_tdata[2*TW-1:TW];
   assign f_di = req_tdata[3*TW-1:2*TW];
   assign f_ri = req_tdata[4*TW-1:3*TW];
   assign f_rj = req_tdata[5*TW-1:4*TW];
   assign f_ki = req_tdata[5*TW+RW-1:5*TW];
   assign f_kj = req_tdata[5*TW+2*RW-1:5*TW+RW];

   logic [TW-1:0] ti_ff, tj_ff, di_ff, ri_ff, rj_ff;
   logic [RW-1:0] ki_ff, kj_ff, ai_ff, aj_ff;
   logic [TW-1:0] gt_ff;
   logic [PW-1:0] gk_ff;
   logic signed [CW-1:0] m_ff, diff_ff;

   // Clamped counts
   logic [RW-1:0] ki_c, kj_c;
   always_comb begin
      ki_c = f_ki;
      if (f_ki == '0) ki_c = RW'(1);
      else if (f_ki > RW'(ldlb_pkg::MAX_REPS)) ki_c = RW'(ldlb_pkg::MAX_REPS);
      kj_c = f_kj;
      if (f_kj == '0) kj_c = RW'(1);
      else if (f_kj > RW'(ldlb_pkg::MAX_REPS)) kj_c = RW'(ldlb_pkg::MAX_REPS);
   end

   // Signed views of the stored operands
   logic signed [CW-1:0] ti_s, tj_s, di_s, ri_s, rj_s, gt_s;
   assign ti_s = $signed(CW'(ti_ff));
   assign tj_s = $signed(CW'(tj_ff));
   assign di_s = $signed(CW'(di_ff));
   assign ri_s = $signed(CW'(ri_ff));
   assign rj_s = $signed(CW'(rj_ff));
   assign gt_s = $signed(CW'(gt_ff));

   logic [PW-1:0] prod_si, prod_dj, hyper_i, hyper_j;
   assign prod_si = PW'(ti_ff) * PW'(ai_ff);
   assign prod_dj = PW'(tj_ff) * PW'(aj_ff);
   assign hyper_i = PW'(ti_ff) * PW'(ki_ff);
   assign hyper_j = PW'(tj_ff) * PW'(kj_ff);

   logic signed [CW-1:0] num_n, diff_c, a_val, b_val;
   assign num_n  = ri_s - rj_s + di_s;
   assign diff_c = $signed(CW'(prod_si)) - $signed(CW'(prod_dj));
   assign a_val  = gt_s - m_ff - diff_ff;
   assign b_val  = ti_s - m_ff - diff_ff;

   // Operand registers and pair counters
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ti_ff <= (f_ti == '0) ? TW'(1) : f_ti;
         tj_ff <= (f_tj == '0) ? TW'(1) : f_tj;
         di_ff <= f_di;
         ri_ff <= f_ri;
         rj_ff <= f_rj;
         ki_ff <= ki_c;
         kj_ff <= kj_c;
         ai_ff <= RW'(1);
         aj_ff <= RW'(1);
      end else if (cmd.emit) begin
         if (aj_ff == kj_ff) begin
            aj_ff <= RW'(1);
            ai_ff <= ai_ff + RW'(1);
         end else begin
            aj_ff <= aj_ff + RW'(1);
         end
      end
      if (cmd.diff_save) diff_ff <= diff_c;
   end

   // Binary gcd unit: one halving or subtraction each cycle
   logic [PW-1:0] ga_ff, gb_ff;
   logic [NW-1:0] gsh_ff;
   logic          grun_ff;
   logic [PW-1:0] gres;
   assign gres = ga_ff << gsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grun_ff <= 1'b0;
      end else if (cmd.gcd_start) begin
         grun_ff <= 1'b1;
      end else if (cmd.gt_save || cmd.gk_save) begin
         grun_ff <= 1'b0;
      end
      if (cmd.gcd_start) begin
         ga_ff  <= cmd.gcd_sel ? hyper_i : PW'(ti_ff);
         gb_ff  <= cmd.gcd_sel ? hyper_j : PW'(tj_ff);
         gsh_ff <= '0;
      end else if (grun_ff && (ga_ff != gb_ff)) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff  <= ga_ff >> 1;
            gb_ff  <= gb_ff >> 1;
            gsh_ff <= gsh_ff + NW'(1);
         end else if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff > gb_ff) begin
            ga_ff <= (ga_ff - gb_ff) >> 1;
         end else begin
            gb_ff <= (gb_ff - ga_ff) >> 1;
         end
      end
      if (cmd.gt_save) gt_ff <= TW'(gres);
      if (cmd.gk_save) gk_ff <= gres;
   end

   // Restoring remainder unit: one dividend bit each cycle
   logic signed [CW-1:0] dvd;
   logic [CW-1:0]        dvd_abs;
   logic [PW-1:0]        dvs;
   logic [MW-1:0]        mag_ff;
   logic [EW-1:0]        rem_ff;
   logic [NW-1:0]        cnt_ff;
   logic                 neg_ff, mrun_ff;
   logic [EW:0]          trial;
   logic [PW-1:0]        negmod;
   logic signed [CW-1:0] negmod_s;

   assign dvd     = cmd.mod_sel ? a_val : num_n;
   assign dvd_abs = dvd[CW-1] ? CW'(-dvd) : CW'(dvd);
   assign dvs     = cmd.mod_sel ? gk_ff : PW'(gt_ff);
   assign trial   = {rem_ff, mag_ff[MW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mrun_ff <= 1'b0;
      end else if (cmd.mod_start) begin
         mrun_ff <= 1'b1;
      end
      if (cmd.mod_start) begin
         mag_ff <= dvd_abs[MW-1:0];
         neg_ff <= dvd[CW-1];
         rem_ff <= '0;
         cnt_ff <= NW'(MW);
      end else if (mrun_ff && (cnt_ff != '0)) begin
         mag_ff <= mag_ff << 1;
         cnt_ff <= cnt_ff - NW'(1);
         if (trial >= (EW+1)'(dvs)) rem_ff <= EW'(trial - (EW+1)'(dvs));
         else rem_ff <= trial[EW-1:0];
      end
   end

   // Distance up to the next multiple of the divisor
   always_comb begin
      if (neg_ff) negmod = rem_ff[PW-1:0];
      else if (rem_ff == '0) negmod = '0;
      else negmod = dvs - rem_ff[PW-1:0];
   end
   assign negmod_s = $signed(CW'(negmod));

   always_ff @(posedge clock) begin
      if (cmd.m_save) m_ff <= tj_s + num_n + negmod_s;
   end

   // Bound of the current pair
   logic signed [CW-1:0] pmin_g, lval;
   logic                 has;
   assign pmin_g = a_val + negmod_s;
   assign has    = (pmin_g <= b_val);
   assign lval   = rj_s - ri_s + ti_s - tj_s - pmin_g - diff_ff;

   // Output register
   logic          out_valid_ff;
   logic [RW-1:0] o_ai_ff, o_aj_ff;
   logic [BW-1:0] o_bound_ff;
   logic          o_has_ff, o_last_ff;
   logic          last_pair;
   assign last_pair = (ai_ff == ki_ff) && (aj_ff == kj_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cmd.emit || (out_valid_ff && !rsp_tready);
      end
      if (cmd.emit) begin
         o_ai_ff    <= ai_ff;
         o_aj_ff    <= aj_ff;
         o_has_ff   <= has;
         o_last_ff  <= last_pair;
         o_bound_ff <= has ? {{(BW-CW){lval[CW-1]}}, lval} : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {o_bound_ff, o_aj_ff, o_ai_ff};
   assign rsp_tuser  = o_has_ff;
   assign rsp_tlast  = o_last_ff;

   assign status.gcd_done  = grun_ff && (ga_ff == gb_ff);
   assign status.mod_done  = mrun_ff && (cnt_ff == '0);
   assign status.last_pair = last_pair;
   assign status.out_free  = !out_valid_ff || rsp_tready;

endmodule

// ===== src/let_dependency_latency_bounds.sv =====
// Per request: two gcd runs, one remainder for the offset term, then one remainder per
// execution pair. Requests are handled one at a time, paced by the single bit-serial
// remainder unit shared by all pairs.
// A new request is taken while the final response still waits in the output register.
// Reset is synchronous and active high; it returns the controller to idle and
// empties the output register.
module let_dependency_latency_bounds (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // period_src, period_dst, deadline_src, release_src, release_dst, reps_src, reps_dst
   input  logic [ldlb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // index_src, index_dst, latency_bound
   output logic [ldlb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // has_bound
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   ldlb_pkg::cmd_type    cmd;
   ldlb_pkg::status_type status;

   ldlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ldlb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A request keeps the block busy for at least the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while the previous one is in progress");

   // A pair without a bound carries a zero bound field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[39:8] == 32'd0)
      else $error("bound field not cleared for a pair without a bound");

   // Execution indices count from one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] != 4'd0) && (rsp_tdata[7:4] != 4'd0))
      else $error("execution index of zero in a response");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

   // One dependency as carried on the request channel
   typedef struct {
      logic [ldlb_pkg::TIME_W-1:0]  period_src;
      logic [ldlb_pkg::TIME_W-1:0]  period_dst;
      logic [ldlb_pkg::TIME_W-1:0]  deadline_src;
      logic [ldlb_pkg::TIME_W-1:0]  release_src;
      logic [ldlb_pkg::TIME_W-1:0]  release_dst;
      logic [ldlb_pkg::REPS_W-1:0]  reps_src;
      logic [ldlb_pkg::REPS_W-1:0]  reps_dst;
      bit                           typed;
      bit                           typed_has;
      logic [ldlb_pkg::BOUND_W-1:0] typed_bound;
   } dep_type;

   // One execution pair as carried on the response channel
   typedef struct {
      logic [ldlb_pkg::REPS_W-1:0]  index_src;
      logic [ldlb_pkg::REPS_W-1:0]  index_dst;
      logic                         has_bound;
      logic [ldlb_pkg::BOUND_W-1:0] latency_bound;
      logic                         last;
   } pair_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // period_src, period_dst, deadline_src, release_src, release_dst, reps_src, reps_dst
   logic [ldlb_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // index_src, index_dst, latency_bound
   logic [ldlb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // has_bound
   logic                            rsp_tuser;
   logic                            rsp_tlast;

   pair_type pending_pairs[$];
   dep_type  sent_deps[$];
   dep_type  directed[$];
   int       error_count = 0;
   bit       quiet = 1'b0;
   int       ready_hold = 0;

   let_dependency_latency_bounds u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic longint gcd_of(longint a, longint b);
      longint t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint ceil_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a > 0) q++;
      return q;
   endfunction

   function automatic longint clamp_count(logic [ldlb_pkg::REPS_W-1:0] r);
      if (r == 0) return 1;
      if (r > ldlb_pkg::MAX_REPS) return ldlb_pkg::MAX_REPS;
      return r;
   endfunction

   // Work out every pair of one dependency and queue the expected bounds.
   task automatic predict_bounds(dep_type d);
      longint ti, tj, di, ri, rj, ki, kj, gt, gk, m, alpha, pmin, pmax, l;
      pair_type p;
      ti = (d.period_src == 0) ? 1 : d.period_src;
      tj = (d.period_dst == 0) ? 1 : d.period_dst;
      di = d.deadline_src;
      ri = d.release_src;
      rj = d.release_dst;
      ki = clamp_count(d.reps_src);
      kj = clamp_count(d.reps_dst);
      gt = gcd_of(ti, tj);
      gk = gcd_of(ti * ki, tj * kj);
      m = tj + ceil_div(ri - rj + di, gt) * gt;
      for (longint ai = 1; ai <= ki; ai++) begin
         for (longint aj = 1; aj <= kj; aj++) begin
            alpha = (ti * ai - tj * aj) / gt;
            pmin = ceil_div(-m + gt - alpha * gt, gk);
            pmax = floor_div(-m + ti - alpha * gt, gk);
            p.index_src = ai[ldlb_pkg::REPS_W-1:0];
            p.index_dst = aj[ldlb_pkg::REPS_W-1:0];
            p.has_bound = (pmin <= pmax);
            p.latency_bound = '0;
            if (pmin <= pmax) begin
               l = rj - ri + ti - tj - (pmin * gk + alpha * gt);
               if (l > 64'sd2147483647) l = 64'sd2147483647;
               if (l < -64'sd2147483648) l = -64'sd2147483648;
               p.latency_bound = l[ldlb_pkg::BOUND_W-1:0];
            end
            p.last = (ai == ki && aj == kj);
            if (d.typed) begin
               p.has_bound = d.typed_has;
               p.latency_bound = d.typed_bound;
            end
            pending_pairs.push_back(p);
         end
      end
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   // Predict on each accepted request and check each accepted response.
   always @(posedge clock) begin
      pair_type want;
      if (!reset && req_tvalid && req_tready)
         predict_bounds(sent_deps.pop_front());
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pairs.size() == 0) begin
            report("unexpected response", 64'(rsp_tdata), 64'd0);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_tdata[3:0] !== want.index_src)
               report("index_src", 64'(rsp_tdata[3:0]), 64'(want.index_src));
            if (rsp_tdata[7:4] !== want.index_dst)
               report("index_dst", 64'(rsp_tdata[7:4]), 64'(want.index_dst));
            if (rsp_tdata[39:8] !== want.latency_bound)
               report("latency_bound", 64'(rsp_tdata[39:8]), 64'(want.latency_bound));
            if (rsp_tuser !== want.has_bound)
               report("has_bound", 64'(rsp_tuser), 64'(want.has_bound));
            if (rsp_tlast !== want.last)
               report("last", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // Receiver back-pressure in bursts, none in the closing stretch.
   always @(negedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= ~rsp_tready;
         ready_hold <= int'($urandom_range(0, 10));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic dep_type make_dep(int ps, int pd, int dl, int rs, int rd, int ks, int kd);
      dep_type d;
      d.period_src = ldlb_pkg::TIME_W'(ps);
      d.period_dst = ldlb_pkg::TIME_W'(pd);
      d.deadline_src = ldlb_pkg::TIME_W'(dl);
      d.release_src = ldlb_pkg::TIME_W'(rs);
      d.release_dst = ldlb_pkg::TIME_W'(rd);
      d.reps_src = ldlb_pkg::REPS_W'(ks);
      d.reps_dst = ldlb_pkg::REPS_W'(kd);
      d.typed = 1'b0;
      d.typed_has = 1'b0;
      d.typed_bound = '0;
      return d;
   endfunction

   function automatic dep_type random_dep();
      dep_type d;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         d = make_dep($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                      $urandom_range(0, 100), $urandom_range(0, 100), 1, 1);
      end else begin
         d = make_dep($urandom, $urandom, $urandom, $urandom, $urandom, 1, 1);
      end
      sel = $urandom_range(0, 19);
      if (sel < 17) begin
         d.reps_src = ldlb_pkg::REPS_W'($urandom_range(1, 4));
         d.reps_dst = ldlb_pkg::REPS_W'($urandom_range(1, 4));
      end else if (sel < 19) begin
         d.reps_src = ldlb_pkg::REPS_W'($urandom_range(1, 8));
         d.reps_dst = ldlb_pkg::REPS_W'($urandom_range(1, 8));
      end else begin
         d.reps_src = ldlb_pkg::REPS_W'($urandom_range(0, 15));
         d.reps_dst = ldlb_pkg::REPS_W'($urandom_range(0, 15));
      end
      return d;
   endfunction

   // Offer one request and wait until it is taken.
   task automatic send_dep(dep_type d);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, d.reps_dst, d.reps_src, d.release_dst, d.release_src,
                    d.deadline_src, d.period_dst, d.period_src};
      sent_deps.push_back(d);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      dep_type d;
      int gap;
      int wait_cycles;
      // Directed rows; the unit case and its zero-period twin give L = 1.
      d = make_dep(1, 1, 1, 0, 0, 1, 1);
      d.typed = 1'b1; d.typed_has = 1'b1; d.typed_bound = 1;
      directed.push_back(d);
      d = make_dep(0, 0, 1, 0, 0, 1, 1);
      d.typed = 1'b1; d.typed_has = 1'b1; d.typed_bound = 1;
      directed.push_back(d);
      directed.push_back(make_dep(0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_dep('hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 15, 15));
      directed.push_back(make_dep('hFFFFF, 1, 'hFFFFF, 0, 'hFFFFF, 8, 8));
      directed.push_back(make_dep(1, 'hFFFFF, 1, 'hFFFFF, 0, 8, 1));
      directed.push_back(make_dep(6, 4, 5, 2, 3, 2, 3));
      directed.push_back(make_dep(7, 5, 3, 0, 9, 5, 7));
      directed.push_back(make_dep(10, 10, 10, 10, 10, 3, 3));
      directed.push_back(make_dep(12, 18, 30, 100, 0, 3, 2));
      directed.push_back(make_dep(3, 9, 1, 0, 50, 9, 0));
      directed.push_back(make_dep('h80000, 'h40000, 'h7FFFF, 'h55555, 'hAAAAA, 4, 2));
      directed.push_back(make_dep(5, 5, 100, 0, 0, 1, 8));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_dep(directed[i]);
      for (int n = 0; n < 480; n++) begin
         if (n > 400) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         send_dep(random_dep());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while ((pending_pairs.size() != 0 || sent_deps.size() != 0) && wait_cycles < 400000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);
      if (pending_pairs.size() != 0) begin
         $display("%0d expected responses never arrived", pending_pairs.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("let_dependency_latency_bounds test passed");
      end else begin
         $display("let_dependency_latency_bounds test failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("let_dependency_latency_bounds test failed");
      $finish;
   end
endmodule
